// ----- hw/rtl/gs_pkg.sv -----
`default_nettype none

package gs_pkg;

   // coordinate and intermediate widths
   localparam int COORD_W = 32;
   localparam int PROD_W  = 2 * COORD_W;       // one coordinate product
   localparam int DOT_W   = PROD_W + 2;        // signed sum of three products
   localparam int NUM_W   = 3 * COORD_W;       // u_i * |v.u|
   localparam int QUO_W   = COORD_W;           // projection magnitude
   localparam int TERM_W  = QUO_W + 1;         // signed projection coordinate
   localparam int DIFF_W  = COORD_W + 2;       // one projection removed
   localparam int ACC_W   = COORD_W + 3;       // two projections removed

   // pipeline depths
   localparam int LANE_LAT = QUO_W + 4;
   localparam int PROJ_LAT = LANE_LAT + 3;

   typedef logic signed [COORD_W-1:0] coord_type;

   // data that travels alongside a projection
   typedef struct packed {
      coord_type [2:0]        a;
      coord_type [2:0]        b;
      coord_type [2:0]        c;
      logic [2:0][DIFF_W-1:0] acc;
      logic                   degen;
   } side_type;

   // one finished result
   typedef struct packed {
      coord_type [2:0] first;
      coord_type [2:0] second;
      coord_type [2:0] third;
      logic            degen;
   } res_type;

   // clamp to the signed coordinate range
   function automatic coord_type sat_coord(input logic signed [ACC_W-1:0] v);
      logic [ACC_W-COORD_W:0] top;
      coord_type              r;
      top = v[ACC_W-1:COORD_W-1];
      if ((&top) || !(|top)) begin
         r = v[COORD_W-1:0];
      end else if (v[ACC_W-1]) begin
         r = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(COORD_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/gs_lane.sv -----
`default_nettype none

// one coordinate lane: u_i * |n| then a 32-step restoring divide by u.u
module gs_lane (
   input  wire logic                        clock,
   input  wire logic                        en,
   input  wire gs_pkg::coord_type           u,
   input  wire logic [gs_pkg::PROD_W-1:0]   nmag,
   input  wire logic                        nneg,
   input  wire logic [gs_pkg::PROD_W-1:0]   dvs,
   output      logic [gs_pkg::TERM_W-1:0]   term
);

   localparam int CW = gs_pkg::COORD_W;
   localparam int PW = gs_pkg::PROD_W;
   localparam int QW = gs_pkg::QUO_W;
   localparam int NW = gs_pkg::NUM_W;
   localparam int TW = gs_pkg::TERM_W;

   logic [CW-1:0] umag_ff;
   logic [PW-1:0] nmag_ff;
   logic          neg1_ff;
   logic [PW-1:0] dvs1_ff;

   logic [PW-1:0] plo_in, phi_in;
   logic [PW-1:0] plo_ff, phi_ff;
   logic          neg2_ff;
   logic [PW-1:0] dvs2_ff;

   logic [NW-1:0] num_in;

   logic [PW-1:0] r_ff   [QW+1];
   logic [CW-1:0] low_ff [QW+1];
   logic [QW-1:0] q_ff   [QW+1];
   logic          neg_ff [QW+1];
   logic [PW-1:0] dvs_ff [QW+1];

   logic [TW-1:0] term_in, term_ff;

   // magnitude of the coordinate, sign of the product
   always_ff @(posedge clock) begin
      if (en) begin
         umag_ff <= u[CW-1] ? CW'(-u) : u;
         nmag_ff <= nmag;
         neg1_ff <= u[CW-1] ^ nneg;
         dvs1_ff <= dvs;
      end
   end

   // two 32x32 partial products
   always_comb begin
      plo_in = umag_ff * nmag_ff[CW-1:0];
      phi_in = umag_ff * nmag_ff[PW-1:CW];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         plo_ff  <= plo_in;
         phi_ff  <= phi_in;
         neg2_ff <= neg1_ff;
         dvs2_ff <= dvs1_ff;
      end
   end

   // full numerator, loaded into the first divide stage
   assign num_in = NW'({phi_ff, {CW{1'b0}}}) + NW'(plo_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]   <= num_in[NW-1:CW];
         low_ff[0] <= num_in[CW-1:0];
         q_ff[0]   <= '0;
         neg_ff[0] <= neg2_ff;
         dvs_ff[0] <= dvs2_ff;
      end
   end

   // one quotient bit per stage
   for (genvar k = 0; k < QW; k++) begin : g_step
      logic [PW:0]   t;
      logic          ge;
      logic [PW:0]   diff;
      always_comb begin
         t    = {r_ff[k], low_ff[k][CW-1]};
         ge   = t >= {1'b0, dvs_ff[k]};
         diff = t - {1'b0, dvs_ff[k]};
      end
      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k+1]   <= ge ? diff[PW-1:0] : t[PW-1:0];
            low_ff[k+1] <= {low_ff[k][CW-2:0], 1'b0};
            q_ff[k+1]   <= {q_ff[k][QW-2:0], ge};
            neg_ff[k+1] <= neg_ff[k];
            dvs_ff[k+1] <= dvs_ff[k];
         end
      end
   end

   // apply the sign
   always_comb begin
      if (neg_ff[QW]) term_in = TW'(-{1'b0, q_ff[QW]});
      else            term_in = {1'b0, q_ff[QW]};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         term_ff <= term_in;
      end
   end

   assign term = term_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/gs_proj.sv -----
`default_nettype none

// projection of v onto u: per-lane products, merged dot sums, three divide lanes
module gs_proj (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               en,
   input  wire logic                               in_valid,
   input  wire gs_pkg::coord_type [2:0]            in_u,
   input  wire gs_pkg::coord_type [2:0]            in_v,
   input  wire gs_pkg::side_type                   in_side,
   output      logic                               out_valid,
   output      logic [2:0][gs_pkg::TERM_W-1:0]     out_term,
   output      logic                               out_degen,
   output      gs_pkg::side_type                   out_side
);

   localparam int PW = gs_pkg::PROD_W;
   localparam int DW = gs_pkg::DOT_W;
   localparam int LL = gs_pkg::LANE_LAT;
   localparam int PL = gs_pkg::PROJ_LAT;

   logic signed [PW-1:0] sq_in [3];
   logic signed [PW-1:0] pr_in [3];
   logic signed [PW-1:0] sq_ff [3];
   logic signed [PW-1:0] pr_ff [3];
   gs_pkg::coord_type [2:0] u1_ff, u2_ff, u3_ff;

   logic [PW-1:0]        d_in, d_ff, d3_ff;
   logic signed [DW-1:0] n_in, n_ff;
   logic [DW-1:0]        nneg_v;
   logic [PW-1:0]        nmag_ff;
   logic                 nneg_ff;

   logic                 dz_ff [LL+1];
   logic                 valid_ff [PL];
   gs_pkg::side_type     side_ff  [PL];
   logic [2:0][gs_pkg::TERM_W-1:0] lane_term;

   // per-lane products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = $signed(in_u[i]) * $signed(in_u[i]);
         pr_in[i] = $signed(in_v[i]) * $signed(in_u[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= sq_in[i];
            pr_ff[i] <= pr_in[i];
         end
         u1_ff <= in_u;
      end
   end

   // merge the lanes into u.u and v.u
   always_comb begin
      d_in = $unsigned(sq_ff[0]) + $unsigned(sq_ff[1]) + $unsigned(sq_ff[2]);
      n_in = pr_ff[0] + pr_ff[1] + pr_ff[2];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff  <= d_in;
         n_ff  <= n_in;
         u2_ff <= u1_ff;
      end
   end

   // magnitude of v.u, zero divisor check
   assign nneg_v = -n_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         nmag_ff <= n_ff[DW-1] ? nneg_v[PW-1:0] : n_ff[PW-1:0];
         nneg_ff <= n_ff[DW-1];
         d3_ff   <= d_ff;
         u3_ff   <= u2_ff;
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_lane
      gs_lane u_lane (
         .clock (clock),
         .en    (en),
         .u     (u3_ff[i]),
         .nmag  (nmag_ff),
         .nneg  (nneg_ff),
         .dvs   (d3_ff),
         .term  (lane_term[i])
      );
   end

   // zero-divisor flag follows the lanes
   always_ff @(posedge clock) begin
      if (en) begin
         dz_ff[0] <= (d_ff == '0);
         for (int k = 1; k <= LL; k++) dz_ff[k] <= dz_ff[k-1];
      end
   end

   // request sideband delay
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         for (int k = 1; k < PL; k++) side_ff[k] <= side_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PL; k++) valid_ff[k] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < PL; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   // drop the term on a zero divisor
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         out_term[i] = dz_ff[LL] ? '0 : lane_term[i];
      end
   end

   assign out_degen = dz_ff[LL];
   assign out_valid = valid_ff[PL-1];
   assign out_side  = side_ff[PL-1];

endmodule

`default_nettype wire

// ----- hw/rtl/gram_schmidt_3d.sv -----
`default_nettype none

// Classical Gram-Schmidt (no normalization) of three signed Q16.16 vectors a, b, c.
// Fully pipelined: one request per clock while the output buffer has room. The
// path is two projection passes in series (a first pass that removes the a
// component from b and c, a register for the saturated second vector, a second
// pass on it, and the output register); each pass is three coordinate lanes whose
// 32-stage restoring dividers form the quotient one bit per stage. A two-entry
// output buffer lets requests keep entering while a result waits.
// A zero squared norm drops that projection term and sets degenerate.
module gram_schmidt_3d (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire gs_pkg::coord_type req_a_x,
   input  wire gs_pkg::coord_type req_a_y,
   input  wire gs_pkg::coord_type req_a_z,
   input  wire gs_pkg::coord_type req_b_x,
   input  wire gs_pkg::coord_type req_b_y,
   input  wire gs_pkg::coord_type req_b_z,
   input  wire gs_pkg::coord_type req_c_x,
   input  wire gs_pkg::coord_type req_c_y,
   input  wire gs_pkg::coord_type req_c_z,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      gs_pkg::coord_type rsp_first_x,
   output      gs_pkg::coord_type rsp_first_y,
   output      gs_pkg::coord_type rsp_first_z,
   output      gs_pkg::coord_type rsp_second_x,
   output      gs_pkg::coord_type rsp_second_y,
   output      gs_pkg::coord_type rsp_second_z,
   output      gs_pkg::coord_type rsp_third_x,
   output      gs_pkg::coord_type rsp_third_y,
   output      gs_pkg::coord_type rsp_third_z,
   output      logic              rsp_degenerate
);

   localparam int AW = gs_pkg::ACC_W;
   localparam int DF = gs_pkg::DIFF_W;

   logic                           en;
   gs_pkg::side_type               in_side;
   logic                           pa_valid;
   logic [2:0][gs_pkg::TERM_W-1:0] pa_term_b, pa_term_c;
   logic                           pa_degen_b, pa_degen_c;
   gs_pkg::side_type               pa_side;
   logic                           pa_valid_c;
   gs_pkg::side_type               pa_side_c;

   gs_pkg::side_type               m_side_in, m_side_ff;
   logic                           m_valid_ff;

   logic                           pb_valid;
   logic [2:0][gs_pkg::TERM_W-1:0] pb_term;
   logic                           pb_degen;
   gs_pkg::side_type               pb_side;

   gs_pkg::res_type                res_in;
   gs_pkg::res_type                buf_ff [2];
   logic                           wr_ff, rd_ff;
   logic [1:0]                     count_ff;
   logic                           push, pop;

   // whole pipeline moves while the output buffer has room
   assign en        = (count_ff != 2'd2);
   assign req_ready = en;

   always_comb begin
      in_side       = '0;
      in_side.a     = {req_a_z, req_a_y, req_a_x};
      in_side.b     = {req_b_z, req_b_y, req_b_x};
      in_side.c     = {req_c_z, req_c_y, req_c_x};
   end

   // first pass: b and c projected on a
   gs_proj u_proj_ab (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_u      (in_side.a),
      .in_v      (in_side.b),
      .in_side   (in_side),
      .out_valid (pa_valid),
      .out_term  (pa_term_b),
      .out_degen (pa_degen_b),
      .out_side  (pa_side)
   );

   gs_proj u_proj_ac (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_u      (in_side.a),
      .in_v      (in_side.c),
      .in_side   (in_side),
      .out_valid (pa_valid_c),
      .out_term  (pa_term_c),
      .out_degen (pa_degen_c),
      .out_side  (pa_side_c)
   );

   // second vector saturated, third partly reduced
   always_comb begin
      logic signed [AW-1:0] db;
      logic signed [DF-1:0] dc;
      m_side_in   = pa_side;
      for (int i = 0; i < 3; i++) begin
         db = $signed(pa_side.b[i]) - $signed(pa_term_b[i]);
         dc = $signed(pa_side.c[i]) - $signed(pa_term_c[i]);
         m_side_in.b[i]   = gs_pkg::sat_coord(db);
         m_side_in.acc[i] = dc;
      end
      m_side_in.degen = pa_degen_b | pa_degen_c;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_side_ff <= m_side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (en) begin
         m_valid_ff <= pa_valid;
      end
   end

   // second pass: c projected on the second basis vector
   gs_proj u_proj_cu (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (m_valid_ff),
      .in_u      (m_side_ff.b),
      .in_v      (m_side_ff.c),
      .in_side   (m_side_ff),
      .out_valid (pb_valid),
      .out_term  (pb_term),
      .out_degen (pb_degen),
      .out_side  (pb_side)
   );

   // final clamp of the third vector
   always_comb begin
      logic signed [AW-1:0] d3;
      res_in.first  = pb_side.a;
      res_in.second = pb_side.b;
      for (int i = 0; i < 3; i++) begin
         d3 = $signed(pb_side.acc[i]) - $signed(pb_term[i]);
         res_in.third[i] = gs_pkg::sat_coord(d3);
      end
      res_in.degen = pb_side.degen | pb_degen;
   end

   // two-entry output buffer
   assign push = en && pb_valid;
   assign pop  = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ff] <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop)  rd_ff <= ~rd_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   assign rsp_valid      = (count_ff != 2'd0);
   assign rsp_first_x    = buf_ff[rd_ff].first[0];
   assign rsp_first_y    = buf_ff[rd_ff].first[1];
   assign rsp_first_z    = buf_ff[rd_ff].first[2];
   assign rsp_second_x   = buf_ff[rd_ff].second[0];
   assign rsp_second_y   = buf_ff[rd_ff].second[1];
   assign rsp_second_z   = buf_ff[rd_ff].second[2];
   assign rsp_third_x    = buf_ff[rd_ff].third[0];
   assign rsp_third_y    = buf_ff[rd_ff].third[1];
   assign rsp_third_z    = buf_ff[rd_ff].third[2];
   assign rsp_degenerate = buf_ff[rd_ff].degen;

   // buffer occupancy never goes past its two entries
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("output buffer count out of range");

   // a full buffer with no pop keeps its count
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2 && !rsp_ready) |=> count_ff == 2'd2)
      else $error("full output buffer changed without a pop");

   // a zero first vector must be flagged before the second pass
   a_zero_first: assert property (@(posedge clock) disable iff (reset)
      (m_valid_ff && m_side_ff.a == '0) |-> m_side_ff.degen)
      else $error("zero first vector not flagged degenerate");

   // stalled pipeline holds the middle stage
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(m_valid_ff))
      else $error("middle stage moved during a stall");

   // both first-pass units run in lockstep
   a_pass_lockstep: assert property (@(posedge clock) disable iff (reset)
      (pa_valid_c == pa_valid) && (!pa_valid || pa_side_c == pa_side))
      else $error("first-pass units out of step");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [127:0] wide_type;

   // one request: a, b, c as x y z each
   typedef logic [0:8][gs_pkg::COORD_W-1:0] triple_type;

   // one result: first, second, third as x y z each, then degenerate
   typedef struct packed {
      logic [0:8][gs_pkg::COORD_W-1:0] v;
      logic                            dg;
   } basis_type;

   localparam int NUM_RANDOM = 1000;
   localparam int CALM_TAIL  = 150;
   localparam int DRAIN_WAIT = 200;

   localparam logic [31:0] MAXC = 32'h7fff_ffff;
   localparam logic [31:0] MINC = 32'h8000_0000;
   localparam logic [31:0] ONE  = 32'h0001_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic       req_valid = 1'b0;
   logic       req_ready;
   triple_type req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   basis_type  rsp_act;

   basis_type basis_queue[$];
   int        errors = 0;
   bit        calm = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   gram_schmidt_3d DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_a_x       (req_data[0]),
      .req_a_y       (req_data[1]),
      .req_a_z       (req_data[2]),
      .req_b_x       (req_data[3]),
      .req_b_y       (req_data[4]),
      .req_b_z       (req_data[5]),
      .req_c_x       (req_data[6]),
      .req_c_y       (req_data[7]),
      .req_c_z       (req_data[8]),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_first_x   (rsp_act.v[0]),
      .rsp_first_y   (rsp_act.v[1]),
      .rsp_first_z   (rsp_act.v[2]),
      .rsp_second_x  (rsp_act.v[3]),
      .rsp_second_y  (rsp_act.v[4]),
      .rsp_second_z  (rsp_act.v[5]),
      .rsp_third_x   (rsp_act.v[6]),
      .rsp_third_y   (rsp_act.v[7]),
      .rsp_third_z   (rsp_act.v[8]),
      .rsp_degenerate(rsp_act.dg)
   );

   // exact dot product of two 3-vectors
   function automatic wide_type dot3(input wide_type x0, x1, x2, y0, y1, y2);
      return x0 * y0 + x1 * y1 + x2 * y2;
   endfunction

   // clamp to the signed coordinate range
   function automatic wide_type clamp(input wide_type x);
      wide_type hi, lo;
      hi = (wide_type'(1) <<< (gs_pkg::COORD_W - 1)) - 1;
      lo = -hi - 1;
      if (x > hi) return hi;
      if (x < lo) return lo;
      return x;
   endfunction

   // orthogonal basis of one request
   function automatic basis_type orthogonalize(input triple_type t);
      wide_type  a[3], b[3], c[3], u2[3], u3[3];
      wide_type  d, n;
      basis_type r;
      int        i;
      r.dg = 1'b0;
      for (i = 0; i < 3; i++) begin
         a[i]  = $signed(t[i]);
         b[i]  = $signed(t[3+i]);
         c[i]  = $signed(t[6+i]);
         u2[i] = b[i];
         u3[i] = c[i];
      end
      // remove the a component from b and c
      d = dot3(a[0], a[1], a[2], a[0], a[1], a[2]);
      if (d == 0) begin
         r.dg = 1'b1;
      end else begin
         n = dot3(b[0], b[1], b[2], a[0], a[1], a[2]);
         for (i = 0; i < 3; i++) u2[i] = u2[i] - (a[i] * n) / d;
         n = dot3(c[0], c[1], c[2], a[0], a[1], a[2]);
         for (i = 0; i < 3; i++) u3[i] = u3[i] - (a[i] * n) / d;
      end
      for (i = 0; i < 3; i++) u2[i] = clamp(u2[i]);
      // remove the saturated second vector from c
      d = dot3(u2[0], u2[1], u2[2], u2[0], u2[1], u2[2]);
      if (d == 0) begin
         r.dg = 1'b1;
      end else begin
         n = dot3(c[0], c[1], c[2], u2[0], u2[1], u2[2]);
         for (i = 0; i < 3; i++) u3[i] = u3[i] - (u2[i] * n) / d;
      end
      for (i = 0; i < 3; i++) begin
         u3[i]    = clamp(u3[i]);
         r.v[i]   = t[i];
         r.v[3+i] = u2[i][gs_pkg::COORD_W-1:0];
         r.v[6+i] = u3[i][gs_pkg::COORD_W-1:0];
      end
      return r;
   endfunction

   // one random coordinate, mostly moderate magnitudes
   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 9))
         0, 1, 2: return $urandom();
         3:       return $urandom_range(0, 1) ? MAXC : MINC;
         4:       return 32'(0);
         default: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
      endcase
   endfunction

   // random request, some shaped to hit degenerate and dependent cases
   function automatic triple_type rand_triple();
      triple_type t;
      int         i, k;
      for (i = 0; i < 9; i++) t[i] = rand_coord();
      k = $urandom_range(1, 4);
      case ($urandom_range(0, 9))
         0: for (i = 0; i < 3; i++) t[i] = '0;
         1: for (i = 0; i < 3; i++) t[3+i] = t[i] * k;
         2: for (i = 0; i < 3; i++) t[6+i] = t[i] + t[3+i];
         3: for (i = 0; i < 3; i++) begin
               t[i]   = '0;
               t[3+i] = '0;
            end
         default: ;
      endcase
      return t;
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp_v, act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %h, got %h", name, exp_v, act_v);
         errors++;
      end
   endtask

   // result checker
   always @(posedge clock) begin
      basis_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (basis_queue.size() == 0) begin
            $error("result with no request outstanding");
            errors++;
         end else begin
            e = basis_queue.pop_front();
            check_field("first_x",  e.v[0], rsp_act.v[0]);
            check_field("first_y",  e.v[1], rsp_act.v[1]);
            check_field("first_z",  e.v[2], rsp_act.v[2]);
            check_field("second_x", e.v[3], rsp_act.v[3]);
            check_field("second_y", e.v[4], rsp_act.v[4]);
            check_field("second_z", e.v[5], rsp_act.v[5]);
            check_field("third_x",  e.v[6], rsp_act.v[6]);
            check_field("third_y",  e.v[7], rsp_act.v[7]);
            check_field("third_z",  e.v[8], rsp_act.v[8]);
            check_field("degenerate", 32'(e.dg), 32'(rsp_act.dg));
         end
      end
   end

   // receiver stall bursts
   initial begin
      int n;
      @(posedge clock);
      while (!reset) @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            n = $urandom_range(1, 4);
         end else begin
            rsp_ready <= 1'b1;
            n = $urandom_range(1, 8);
         end
         repeat (n) @(posedge clock);
      end
   end

   // send one request and record its expected basis
   task automatic send_request(input triple_type t, input basis_type exp_b);
      int gap;
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      basis_queue.push_back(exp_b);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 4);
         repeat (gap - 1) @(posedge clock);
         @(posedge clock);
      end
   endtask

   // directed requests, expected basis typed in where obvious
   triple_type dir_req[12];
   bit         dir_known[12];
   basis_type  dir_exp[12];

   initial begin
      int         i;
      triple_type t;
      basis_type  e;
      dir_req   = '{default: '0};
      dir_known = '{default: 1'b0};
      dir_exp   = '{default: '0};
      // all zero: both divisors zero
      dir_known[0] = 1'b1;
      dir_exp[0].dg = 1'b1;
      // orthonormal inputs come back unchanged
      dir_req[1] = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
      dir_known[1] = 1'b1;
      dir_exp[1].v = dir_req[1];
      dir_req[2] = '{default: MAXC};
      dir_req[3] = '{default: MINC};
      dir_req[4] = '{MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC, MAXC, MINC};
      dir_req[5] = '{MINC, MINC, MINC, MAXC, 0, MINC, MAXC, MAXC, MAXC};
      // first vector zero
      dir_req[6] = '{0, 0, 0, 32'h0003_0000, 32'hfffe_0000, ONE, ONE, ONE, ONE};
      // second vector parallel to the first
      dir_req[7] = '{ONE, 32'h0002_0000, 32'h0003_0000, 32'h0002_0000,
                     32'h0004_0000, 32'h0006_0000, 32'h0005_0000, 32'hffff_0000, 7};
      // third vector in the span of the first two
      dir_req[8] = '{ONE, 0, ONE, 0, ONE, ONE, ONE, ONE, 32'h0002_0000};
      dir_req[9] = '{1, 0, 0, 32'hffff_ffff, 1, 0, 3, 32'hffff_fffd, 5};
      // a zero and b zero
      dir_req[10] = '{0, 0, 0, 0, 0, 0, MAXC, 5, MINC};
      dir_req[11] = '{32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678, 32'hedcb_a987,
                      32'h0f0f_0f0f, 32'hf0f0_f0f0, 32'h8000_0001, 32'h7fff_fffe, 1};

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < 12; i++) begin
         e = dir_known[i] ? dir_exp[i] : orthogonalize(dir_req[i]);
         send_request(dir_req[i], e);
      end
      for (i = 0; i < NUM_RANDOM; i++) begin
         if (i == NUM_RANDOM - CALM_TAIL) calm = 1'b1;
         t = rand_triple();
         send_request(t, orthogonalize(t));
      end
      req_valid <= 1'b0;

      while (basis_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0 && basis_queue.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire
